// ===== rtl/cle_pkg.sv =====
// cle_pkg: shared types and constants for the circular list engine
// opcodes, status codes, sequencer states and memory write masks
// no dependencies
package cle_pkg;

  localparam int OPCODE_W       = 3;
  localparam int VALUE_W        = 32;
  localparam int POS_W          = 7;
  localparam int STATUS_W       = 3;
  localparam int INDEX_W        = 7;
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_SEARCH   = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BADPOS   = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_WR1,
    S_WR2,
    S_WR3,
    S_DONE
  } state_t;

  // per-field write enables of the node memory
  typedef struct packed {
    logic value_en;
    logic next_en;
    logic prev_en;
  } wmask_t;

endpackage

// ===== rtl/cle_if.sv =====
// cle_req_if / cle_rsp_if: valid-ready channels of the circular list engine
// request carries one operation, response carries one result beat
// depends on cle_pkg
interface cle_req_if import cle_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface cle_rsp_if import cle_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [INDEX_W-1:0]   found_index;
  logic [INDEX_W-1:0]   entry_count;

  modport source (output valid, output status, output found_index, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_index, input entry_count,
                  output ready);
endinterface

// ===== rtl/circular_list_engine_top.sv =====
// circular_list_engine_top: circular doubly linked list in a node memory with a free stack
// depends on cle_pkg and cle_if
//
//  channel   | role   | handshake     | payload
//  request   | sink   | valid / ready | opcode, value, position
//  result    | source | valid / ready | status, found_index, entry_count
//
// one item at a time: accept, setup, then one node-memory read per cycle while walking
// k links (k = position - 1, 0 for an append, or up to entry count reads for a search),
// the write states S_WR1 to S_WR3 as needed and S_DONE to load the result register;
// an item refused at setup goes straight to S_DONE
// reset empties the list at once, node memory needs no clearing
// a new request is taken while the previous result beat still waits in its register

module circular_list_engine_top import cle_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cle_req_if.sink   request,
  cle_rsp_if.source result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [AW-1:0]         next_link;
    logic [AW-1:0]         prev_link;
  } node_t;

  // control state
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] rtop, rtop_next;     // recycled slots on the free stack
  logic [CW-1:0] fresh, fresh_next;   // slots never handed out sit at fresh and above
  logic          out_valid, out_valid_next;

  // item and walk registers
  opcode_t               op;
  logic [DATA_WIDTH-1:0] key;
  logic [POS_W-1:0]      pos;
  logic [CW-1:0]         remain;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         found;
  logic [AW-1:0]         cur, xs, ps, nxs, ns;
  logic                  is_ins, is_search, front, multi;
  status_t               stat;
  logic [STATUS_W-1:0]   out_status;
  logic [INDEX_W-1:0]    out_found;
  logic [INDEX_W-1:0]    out_count;

  // memories
  node_t         node_mem [CAPACITY];
  node_t         rd_q;
  logic [AW-1:0] free_mem [CAPACITY];
  logic [AW-1:0] free_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  wmask_t        wr_mask;
  node_t         wr_data;
  logic          fr_rd_en;
  logic          fr_wr_en;
  logic [CW-1:0] rtop_dec;

  // setup decode
  logic [PW-1:0] pos_w, cnt_w, ins_p, del_p;
  status_t       setup_stat;
  logic          setup_go, s_ins, s_search, s_front;
  logic [CW-1:0] steps;
  logic          full;
  logic          match;
  logic          walk_end;

  assign request.ready      = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.found_index = out_found;
  assign result.entry_count = out_count;

  assign rtop_dec = rtop - 1'b1;
  assign match    = (rd_q.value == key);
  assign walk_end = (remain == '0);
  assign full     = (count == CW'(CAPACITY));

  always_comb begin
    pos_w      = PW'(pos);
    cnt_w      = PW'(count);
    ins_p      = (op == OP_INS_HEAD) ? PW'(1) : (op == OP_INS_TAIL) ? cnt_w + 1'b1 : pos_w;
    del_p      = (op == OP_DEL_HEAD) ? PW'(1) : (op == OP_DEL_TAIL) ? cnt_w : pos_w;
    setup_stat = STAT_OK;
    setup_go   = 1'b0;
    s_ins      = 1'b0;
    s_search   = 1'b0;
    s_front    = 1'b0;
    steps      = '0;
    unique case (op)
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
        s_ins = 1'b1;
        if (ins_p == '0 || ins_p > cnt_w + 1'b1) begin
          setup_stat = STAT_BADPOS;
        end else if (full) begin
          setup_stat = STAT_FULL;
        end else begin
          setup_go = 1'b1;
          s_front  = (ins_p == PW'(1));
          // appending links in front of the head like an insert at the head, but the head stays
          steps    = (ins_p == cnt_w + 1'b1) ? '0 : CW'(ins_p - 1'b1);
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (count == '0) begin
          setup_stat = STAT_EMPTY;
        end else begin
          setup_go = 1'b1;
          steps    = CW'(del_p - 1'b1);
        end
      end
      OP_DEL_POS: begin
        if (del_p == '0 || del_p > cnt_w) begin
          setup_stat = STAT_BADPOS;
        end else begin
          setup_go = 1'b1;
          steps    = CW'(del_p - 1'b1);
        end
      end
      OP_SEARCH: begin
        if (count == '0) begin
          setup_stat = STAT_EMPTY;
        end else begin
          setup_go = 1'b1;
          s_search = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state and memory port control
  always_comb begin
    state_next     = state;
    count_next     = count;
    head_next      = head;
    rtop_next      = rtop;
    fresh_next     = fresh;
    out_valid_next = out_valid & ~result.ready;
    rd_en          = 1'b0;
    rd_addr        = head;
    fr_rd_en       = 1'b0;
    fr_wr_en       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = ns;
    wr_mask        = '0;
    wr_data        = '{value: key, next_link: xs, prev_link: ps};
    unique case (state)
      S_IDLE: begin
        if (request.valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        rd_en      = 1'b1;
        rd_addr    = head;
        fr_rd_en   = (rtop != '0);
        state_next = setup_go ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (is_search) begin
          if (match || idx == count) begin
            state_next = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_q.next_link;
          end
        end else if (walk_end) begin
          state_next = S_WR1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_q.next_link;
        end
      end
      S_WR1: begin
        if (is_ins) begin
          wr_en      = 1'b1;
          wr_addr    = ns;
          wr_mask    = '{value_en: 1'b1, next_en: 1'b1, prev_en: 1'b1};
          count_next = count + 1'b1;
          if (rtop != '0) rtop_next = rtop_dec;
          else fresh_next = fresh + 1'b1;
          if (count == '0) begin
            // first node links to itself
            wr_data    = '{value: key, next_link: ns, prev_link: ns};
            head_next  = ns;
            state_next = S_DONE;
          end else begin
            state_next = S_WR2;
          end
        end else begin
          fr_wr_en   = 1'b1;
          rtop_next  = rtop + 1'b1;
          count_next = count - 1'b1;
          if (multi) begin
            wr_en      = 1'b1;
            wr_addr    = ps;
            wr_mask    = '{value_en: 1'b0, next_en: 1'b1, prev_en: 1'b0};
            wr_data    = '{value: key, next_link: nxs, prev_link: ps};
            state_next = S_WR2;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WR2: begin
        wr_en = 1'b1;
        if (is_ins) begin
          wr_addr    = ps;
          wr_mask    = '{value_en: 1'b0, next_en: 1'b1, prev_en: 1'b0};
          wr_data    = '{value: key, next_link: ns, prev_link: ps};
          state_next = S_WR3;
        end else begin
          wr_addr    = nxs;
          wr_mask    = '{value_en: 1'b0, next_en: 1'b0, prev_en: 1'b1};
          wr_data    = '{value: key, next_link: nxs, prev_link: ps};
          if (xs == head) head_next = nxs;
          state_next = S_DONE;
        end
      end
      S_WR3: begin
        wr_en      = 1'b1;
        wr_addr    = xs;
        wr_mask    = '{value_en: 1'b0, next_en: 1'b0, prev_en: 1'b1};
        wr_data    = '{value: key, next_link: xs, prev_link: ns};
        if (front) head_next = ns;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      rtop      <= '0;
      fresh     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head      <= head_next;
      rtop      <= rtop_next;
      fresh     <= fresh_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      op  <= opcode_t'(request.opcode);
      key <= DATA_WIDTH'(request.value);
      pos <= request.position;
    end
    unique case (state)
      S_SETUP: begin
        cur       <= head;
        remain    <= steps;
        idx       <= CW'(1);
        found     <= '0;
        stat      <= setup_stat;
        is_ins    <= s_ins;
        is_search <= s_search;
        front     <= s_front;
        multi     <= (count > CW'(1));
      end
      S_WALK: begin
        if (is_search) begin
          if (match) found <= idx;
          else if (idx == count) stat <= STAT_NOTFOUND;
          else idx <= idx + 1'b1;
        end else if (walk_end) begin
          xs  <= cur;
          ps  <= rd_q.prev_link;
          nxs <= rd_q.next_link;
          ns  <= (rtop != '0) ? free_q : fresh[AW-1:0];
        end else begin
          remain <= remain - 1'b1;
          cur    <= rd_q.next_link;
        end
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          out_status <= stat;
          out_found  <= INDEX_W'(found);
          out_count  <= INDEX_W'(count);
        end
      end
      default: ;
    endcase
  end

  // node memory: one read port, one write port with field enables
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_mask.value_en) node_mem[wr_addr].value     <= wr_data.value;
      if (wr_mask.next_en)  node_mem[wr_addr].next_link <= wr_data.next_link;
      if (wr_mask.prev_en)  node_mem[wr_addr].prev_link <= wr_data.prev_link;
    end
    if (rd_en) rd_q <= node_mem[rd_addr];
  end

  // free stack of recycled slots
  always_ff @(posedge clk) begin
    if (fr_wr_en) free_mem[rtop[AW-1:0]] <= xs;
    if (fr_rd_en) free_q <= free_mem[rtop_dec[AW-1:0]];
  end

endmodule

// ===== rtl/cle_checker.sv =====
// cle_checker: port-level assertions for circular_list_engine_top
// bound to the top level below; depends on cle_pkg
module cle_checker import cle_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [INDEX_W-1:0]  found_index,
  input logic [INDEX_W-1:0]  entry_count
);

  logic       in_beat, out_beat;
  logic [1:0] owed;   // accepted requests whose result beat is still to come

  assign in_beat  = in_valid & in_ready;
  assign out_beat = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else if (in_beat && !out_beat) begin
      owed <= owed + 1'b1;
    end else if (!in_beat && out_beat) begin
      owed <= owed - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_index)
      && $stable(entry_count))
    else $error("result beat changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> owed != 2'd0)
    else $error("result beat without a request");

  a_one_pending: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> owed <= 2'd1)
    else $error("request taken with two results owed");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_index != '0 |-> status == STAT_OK)
    else $error("found index on a failed result");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> entry_count == '0)
    else $error("empty status with entries present");

endmodule

bind circular_list_engine_top cle_checker #(.CAPACITY(CAPACITY)) u_cle_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (request.valid),
  .in_ready    (request.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .status      (result.status),
  .found_index (result.found_index),
  .entry_count (result.entry_count)
);
